FILE: sv/gcr62_pkg.sv
package gcr62_pkg;

    // Sector layout
    localparam int AuxLen      = 86;
    localparam int SectorBytes = 343;
    localparam int LastPos     = SectorBytes - 1;

    localparam int PosW   = $clog2(SectorBytes);
    localparam int AuxAw  = $clog2(AuxLen);
    localparam int ValW   = 6;
    localparam int ShiftW = 2;
    localparam int ErrW   = 9;

    // Last pass over the aux store uses bits [5:4]
    localparam logic [ShiftW-1:0] LastShift = ShiftW'(2);

    // Result packing
    localparam int OutDataW = 24;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic            valid;
        logic [ValW-1:0] value;
    } code_t;

    typedef struct packed {
        logic             en;
        logic [AuxAw-1:0] addr;
        logic [ValW-1:0]  data;
    } aux_wr_t;

    typedef struct packed {
        logic             en;
        logic [AuxAw-1:0] addr;
    } aux_rd_t;

    localparam byte_t CodeWords [64] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    // Map a disk byte to its 6-bit value; each code word is unique
    function automatic code_t gcr62_decode(input byte_t b);
        code_t r;
        r = '0;
        for (int k = 0; k < 64; k++) begin
            if (b == CodeWords[k]) begin
                r.valid = 1'b1;
                r.value = ValW'(k);
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/gcr62_aux_ram.sv
module gcr62_aux_ram (
    input  logic                         aclk,
    input  gcr62_pkg::aux_wr_t           wr,
    input  gcr62_pkg::aux_rd_t           rd,
    output logic [gcr62_pkg::ValW-1:0]   rd_data
);
    import gcr62_pkg::*;

    logic [ValW-1:0] mem [AuxLen];
    logic [ValW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port; hold data between reads
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

`ifndef SYNTHESIS
    a_no_same_entry: assert property (@(posedge aclk)
        wr.en && rd.en |-> wr.addr != rd.addr)
        else $error("aux store read and write hit the same entry");
    a_wr_in_range: assert property (@(posedge aclk)
        wr.en |-> int'(wr.addr) < AuxLen)
        else $error("aux store write address out of range");
    a_rd_in_range: assert property (@(posedge aclk)
        rd.en |-> int'(rd.addr) < AuxLen)
        else $error("aux store read address out of range");
`endif

endmodule

FILE: sv/gcr62_sector_decoder.sv
// GCR 6-and-2 sector data-field decoder.
// Input stream: one raw disk byte per transaction on s_tdata[7:0]; a sector
// is 343 bytes: 86 auxiliary bytes, 256 data bytes, one checksum byte.
// Output stream: one transaction per data byte (m_tdata[7:0]) and one
// status transaction after the checksum byte, marked by m_tlast, carrying
// the error count and the checksum match flag. Aux bytes give no output.
// Throughput: one byte per cycle, sustained while the receiver does not stall, with no gap between sectors.
// A data or status result is held in the read stage while its aux store
// read completes, then in the output register, which drives m_*.
// The low bits of each data byte come from a 86x6 aux RAM written during
// the aux phase and read once per data byte; its single read port and its
// registered read set the two-stage pipeline.
// Reset (aresetn low, synchronous) returns to the start of a sector and
// empties the pipeline; aux RAM contents are not cleared.
// When the receiver stalls, the output register holds its result and the
// read stage behind it takes one more data or status byte, then s_tready
// drops; aux bytes keep flowing while the read stage is empty.
module gcr62_sector_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // [7:0] disk_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] data_byte, [16:8] error_count, [17] checksum_ok, [23:18] zero
    output logic [gcr62_pkg::OutDataW-1:0]    m_tdata,
    output logic                              m_tlast   // sector_end
);
    import gcr62_pkg::*;

    // Sector state
    logic [PosW-1:0]   pos_reg;
    logic [ValW-1:0]   rv_reg;
    logic [ErrW-1:0]   bad_reg;
    logic [AuxAw-1:0]  idx_reg;
    logic [ShiftW-1:0] shift_reg;

    // Read stage
    logic              s1_valid_reg;
    logic              s1_status_reg;
    logic [ValW-1:0]   s1_hi_reg;
    logic [ShiftW-1:0] s1_shift_reg;
    logic [ErrW-1:0]   s1_errs_reg;
    logic              s1_ok_reg;

    // Output register
    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    logic [ErrW-1:0]   m_errs_reg;
    logic              m_ok_reg;
    logic              m_last_reg;

    code_t             dec;
    logic [ValW-1:0]   val;
    logic [ValW-1:0]   rv_next;
    logic [ErrW-1:0]   bad_next;
    logic              is_aux;
    logic              is_status;
    logic              accept;
    logic              out_free;
    logic              s1_take;
    logic              ok;
    logic [ErrW-1:0]   errs;
    aux_wr_t           aux_wr;
    aux_rd_t           aux_rd;
    logic [ValW-1:0]   aux_data;
    logic [1:0]        low_bits;

    // Decode and un-chain the incoming byte
    always_comb begin
        dec       = gcr62_decode(s_tdata);
        val       = dec.valid ? dec.value : '0;
        rv_next   = rv_reg ^ val;
        bad_next  = bad_reg + ErrW'(!dec.valid);
        is_aux    = pos_reg < PosW'(AuxLen);
        is_status = pos_reg == PosW'(LastPos);
        ok        = val == rv_reg;
        errs      = bad_next + ErrW'(!ok);
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s1_take  = !s1_valid_reg || out_free;
    assign s_tready = s1_take;
    assign accept   = s_tvalid && s1_take;

    // Aux store access: write in the aux phase, read for each data byte
    always_comb begin
        aux_wr.en   = accept && is_aux;
        aux_wr.addr = pos_reg[AuxAw-1:0];
        aux_wr.data = rv_next;
        aux_rd.en   = accept && !is_aux && !is_status;
        aux_rd.addr = idx_reg;
    end

    gcr62_aux_ram u_aux_ram (
        .aclk    (aclk),
        .wr      (aux_wr),
        .rd      (aux_rd),
        .rd_data (aux_data)
    );

    // Advance sector position and running value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            rv_reg    <= '0;
            bad_reg   <= '0;
            idx_reg   <= '0;
            shift_reg <= '0;
        end else if (accept) begin
            if (is_status) begin
                pos_reg   <= '0;
                rv_reg    <= '0;
                bad_reg   <= '0;
                idx_reg   <= '0;
                shift_reg <= '0;
            end else begin
                pos_reg <= pos_reg + PosW'(1);
                rv_reg  <= rv_next;
                bad_reg <= bad_next;
                if (!is_aux) begin
                    if (idx_reg == AuxAw'(AuxLen - 1)) begin
                        idx_reg   <= '0;
                        shift_reg <= shift_reg + ShiftW'(1);
                    end else begin
                        idx_reg <= idx_reg + AuxAw'(1);
                    end
                end
            end
        end
    end

    // Load the read stage while the aux RAM fetches
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_take) begin
            s1_valid_reg <= accept && !is_aux;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_take) begin
            s1_status_reg <= is_status;
            s1_hi_reg     <= rv_next;
            s1_shift_reg  <= shift_reg;
            s1_errs_reg   <= errs;
            s1_ok_reg     <= ok;
        end
    end

    // Select the two low bits of the aux entry
    always_comb begin
        unique case (s1_shift_reg)
            2'd0:    low_bits = aux_data[1:0];
            2'd1:    low_bits = aux_data[3:2];
            default: low_bits = aux_data[5:4];
        endcase
    end

    // Output register; hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (s1_status_reg) begin
                m_byte_reg <= '0;
                m_errs_reg <= s1_errs_reg;
                m_ok_reg   <= s1_ok_reg;
                m_last_reg <= 1'b1;
            end else begin
                m_byte_reg <= {s1_hi_reg, low_bits};
                m_errs_reg <= '0;
                m_ok_reg   <= 1'b0;
                m_last_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(OutDataW - 8 - ErrW - 1)'(0), m_ok_reg, m_errs_reg, m_byte_reg};

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PosW'(LastPos))
        else $error("sector position past the checksum byte");
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_reg <= LastShift)
        else $error("aux shift past the last pass");
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |-> !s_tready)
        else $error("input taken while read stage is stalled");
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_byte_reg == 8'd0)
        else $error("status result carries a data byte");
    a_status_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_status |=> pos_reg == '0 && rv_reg == '0 && bad_reg == '0)
        else $error("sector state not cleared after checksum byte");
`endif

endmodule

FILE: tb/sv/gcr62_sector_decoder_tb.sv
module gcr62_sector_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcr62_pkg::*;

    localparam int CycleLimit    = 500_000;
    localparam int DrainCycles   = 12;
    localparam int RandomSectors = 1;

    // One result transaction, split into its fields
    typedef struct packed {
        logic [7:0] data_byte;
        logic       sector_end;
        logic [8:0] error_count;
        logic       checksum_ok;
    } decoded_result_t;

    // Directed sector: first byte, fill byte for the rest, checksum byte,
    // and the status that can be worked out by hand
    typedef struct packed {
        byte_t      first_byte;
        byte_t      fill_byte;
        byte_t      check_byte;
        logic [8:0] status_errors;
        logic       status_ok;
    } sector_recipe_t;

    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_RANDOM,
        SINK_STALLS
    } sink_mode_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Inverse of the 6-and-2 code table, built at start
    bit          code_valid [256];
    logic [5:0]  code_value [256];

    // Predictor state
    logic [8:0]  sector_pos;
    logic [5:0]  chain_value;
    logic [5:0]  low_bits_store [AuxLen];
    logic [8:0]  bad_count;

    decoded_result_t pending_results [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    sink_mode_e  sink_mode = SINK_FREE;

    sector_recipe_t directed_sectors [1] = '{
        {8'h00, 8'h00, 8'h00, 9'd343, 1'b1}   // every byte invalid
    };

    gcr62_sector_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Advance the predictor by one disk byte; return 1 if it yields a result
    function automatic bit predict_sector_byte(input byte_t raw, output decoded_result_t res);
        logic [5:0] value;
        logic [8:0] data_index;
        logic [5:0] aux_entry;
        bit         match;
        res = '0;
        value = code_valid[raw] ? code_value[raw] : 6'd0;
        if (!code_valid[raw]) bad_count = bad_count + 9'd1;

        // Checksum byte closes the sector
        if (sector_pos >= 9'(LastPos)) begin
            match = (value == chain_value);
            res.sector_end  = 1'b1;
            res.error_count = bad_count + (match ? 9'd0 : 9'd1);
            res.checksum_ok = match;
            sector_pos  = '0;
            chain_value = '0;
            bad_count   = '0;
            return 1'b1;
        end

        chain_value = chain_value ^ value;
        if (sector_pos < 9'(AuxLen)) begin
            low_bits_store[sector_pos] = chain_value;
            sector_pos = sector_pos + 9'd1;
            return 1'b0;
        end

        // Data byte: chained value on top, two low bits from the aux entry
        data_index = sector_pos - 9'(AuxLen);
        aux_entry  = low_bits_store[data_index % AuxLen];
        res.data_byte = {chain_value, 2'(aux_entry >> (2 * (data_index / AuxLen)))};
        sector_pos = sector_pos + 9'd1;
        return 1'b1;
    endfunction

    // Offer one byte, wait for its transaction, record the expectation, and pause between bursts
    task automatic send_disk_byte(input byte_t b, input bit typed,
                                  input logic [8:0] typed_errors, input logic typed_ok);
        decoded_result_t res;
        bit              has_result;
        int              gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        has_result = predict_sector_byte(b, res);
        if (has_result) begin
            if (typed && res.sector_end) begin
                res.error_count = typed_errors;
                res.checksum_ok = typed_ok;
            end
            pending_results.push_back(res);
        end

        // Bursts of random length, separated by random gaps
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 48);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Random sector: mostly well-formed, some with noise or a broken checksum
    task automatic send_random_sector();
        int         kind;
        byte_t      b;
        logic [5:0] chain;
        kind  = $urandom_range(9);
        chain = '0;
        for (int pos = 0; pos < SectorBytes; pos++) begin
            if (pos == LastPos) begin
                if (kind < 6) b = CodeWords[chain];
                else if (kind < 8) b = CodeWords[$urandom_range(63)];
                else b = byte_t'($urandom_range(255));
            end else if (kind == 9 || (kind >= 6 && $urandom_range(15) == 0)) begin
                b = byte_t'($urandom_range(255));
            end else begin
                b = CodeWords[$urandom_range(63)];
            end
            if (code_valid[b]) chain = chain ^ code_value[b];
            send_disk_byte(b, 1'b0, '0, 1'b0);
        end
    endtask

    task automatic compare_field(input string name, input logic [8:0] expected,
                                 input logic [8:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Receiver: switch at random between free-running, random and burst-stall patterns
    always @(posedge aclk) begin
        if (cycle_count % 256 == 0) sink_mode <= sink_mode_e'($urandom_range(2));
        case (sink_mode)
            SINK_FREE: begin
                m_tready <= 1'b1;
            end
            SINK_RANDOM: begin
                m_tready <= ($urandom_range(3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    m_tready <= 1'b0;
                end else if ($urandom_range(15) == 0) begin
                    stall_left <= $urandom_range(1, 12);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin
        decoded_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: data %0h, last %0b", $time,
                         m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                compare_field("data_byte", 9'(exp_res.data_byte), 9'(m_tdata[7:0]));
                compare_field("sector_end", 9'(exp_res.sector_end), 9'(m_tlast));
                compare_field("error_count", exp_res.error_count, m_tdata[16:8]);
                compare_field("checksum_ok", 9'(exp_res.checksum_ok), 9'(m_tdata[17]));
                compare_field("pad", 9'd0, 9'(m_tdata[23:18]));
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 256; k++) begin
            code_valid[k] = 1'b0;
            code_value[k] = '0;
        end
        for (int k = 0; k < 64; k++) begin
            code_valid[CodeWords[k]] = 1'b1;
            code_value[CodeWords[k]] = 6'(k);
        end
        sector_pos  = '0;
        chain_value = '0;
        bad_count   = '0;
        for (int k = 0; k < AuxLen; k++) low_bits_store[k] = '0;

        // Hold reset at start, then release it
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sectors
        foreach (directed_sectors[r]) begin
            for (int pos = 0; pos < SectorBytes; pos++) begin
                send_disk_byte(pos == 0       ? directed_sectors[r].first_byte :
                               pos == LastPos ? directed_sectors[r].check_byte :
                                                directed_sectors[r].fill_byte,
                               1'b1, directed_sectors[r].status_errors,
                               directed_sectors[r].status_ok);
            end
        end

        // Random sectors
        repeat (RandomSectors) send_random_sector();
        s_tvalid <= 1'b0;

        // Drain the pipeline
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/gcr62_pkg.sv
sv/gcr62_aux_ram.sv
sv/gcr62_sector_decoder.sv
tb/sv/gcr62_sector_decoder_tb.sv
